### hdl/orl_pkg.sv
// Shared types and constants for the overwriting ring log.
`default_nettype none
package orl_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned REC_WORDS = 4;
    localparam int unsigned REC_W     = WORD_W * REC_WORDS;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_COMMIT = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic write;   // store record, advance write index
        logic commit;  // committed index <= cursor
        logic clear;   // zero all indices
        logic marker;  // emit the empty-read marker
        logic rd_step; // read one slot at the cursor, advance cursor
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // cursor == write index
        logic step_last; // next cursor == write index
    } t_dp_stat;

endpackage
`default_nettype wire

### hdl/orl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module orl_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/orl_ctrl.sv
// Command sequencer for the ring log: decodes commands and walks read runs.
`default_nettype none
module orl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire orl_pkg::t_op      i_op,
    input  wire orl_pkg::t_dp_stat i_stat,
    output orl_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        orl_pkg::OP_WRITE:  o_cmd.write  = 1'b1;
                        orl_pkg::OP_COMMIT: o_cmd.commit = 1'b1;
                        orl_pkg::OP_CLEAR:  o_cmd.clear  = 1'b1;
                        orl_pkg::OP_READ: begin
                            if (i_stat.empty) begin
                                o_cmd.marker = 1'b1;
                            end else begin
                                n_state = ST_RUN;
                            end
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.rd_step = 1'b1;
                if (i_stat.step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state == ST_RUN);
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

### hdl/orl_dp.sv
// Ring log datapath: indices, record RAM and result registers.
`default_nettype none
module orl_dp #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire orl_pkg::t_dp_cmd           i_cmd,
    input  wire logic [orl_pkg::REC_W-1:0]  i_rec,
    output orl_pkg::t_dp_stat               o_stat,
    output logic                            o_valid,
    output logic                            o_has_record,
    output logic                            o_last,
    output logic [orl_pkg::REC_W-1:0]       o_rec
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_com, n_com;
    logic          r_out_valid, r_out_has, r_out_last;

    logic [AW-1:0] wr_inc, cur_inc, com_inc;
    logic [orl_pkg::REC_W-1:0] ram_q;

    assign wr_inc  = (r_wr  == LAST_IDX) ? '0 : r_wr  + AW'(1);
    assign cur_inc = (r_cur == LAST_IDX) ? '0 : r_cur + AW'(1);
    assign com_inc = (r_com == LAST_IDX) ? '0 : r_com + AW'(1);

    assign o_stat.empty     = (r_cur == r_wr);
    assign o_stat.step_last = (cur_inc == r_wr);

    always_comb begin
        n_wr  = r_wr;
        n_cur = r_cur;
        n_com = r_com;
        if (i_cmd.clear) begin
            n_wr  = '0;
            n_cur = '0;
            n_com = '0;
        end else if (i_cmd.write) begin
            n_wr = wr_inc;
            // overwrite: push readers ahead of the new write index
            if (wr_inc == r_cur) begin
                n_cur = cur_inc;
            end
            if (wr_inc == r_com) begin
                n_com = com_inc;
            end
        end else if (i_cmd.commit) begin
            n_com = r_cur;
        end else if (i_cmd.rd_step) begin
            n_cur = cur_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_cur       <= '0;
            r_com       <= '0;
            r_out_valid <= 1'b0;
            r_out_has   <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_wr        <= n_wr;
            r_cur       <= n_cur;
            r_com       <= n_com;
            r_out_valid <= i_cmd.rd_step | i_cmd.marker;
            r_out_has   <= i_cmd.rd_step;
            r_out_last  <= i_cmd.marker | (i_cmd.rd_step & o_stat.step_last);
        end
    end

    orl_ram #(
        .WIDTH (orl_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wr),
        .i_wdata (i_rec),
        .i_re    (i_cmd.rd_step),
        .i_raddr (r_cur),
        .o_rdata (ram_q)
    );

    assign o_valid      = r_out_valid;
    assign o_has_record = r_out_has;
    assign o_last       = r_out_last;
    assign o_rec        = r_out_has ? ram_q : '0;

endmodule
`default_nettype wire

### hdl/overwriting_ring_log_with_read_commit.sv
// Top level of the overwriting ring log with read commit.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------
//  command   | start in, busy out        | i_operation, i_rec_word0..i_rec_word3
//  result    | o_valid strobe, one cycle | o_out_word0..3, o_has_record, o_last
//
// A command transaction is taken on a clock edge with start high and busy low.
// Write, commit and clear take effect on that edge; busy stays low.
// A read of n pending records holds busy while the run loop reads them, and emits
// one record per cycle, each the cycle after the RAM read the run loop issues;
// an empty read emits a single marker the cycle after the transaction, without busy.
// Results are strobes; the receiver cannot stall. Reset (i_rst_n low, synchronous)
// zeroes all indices; record contents are not cleared.
`default_nettype none
module overwriting_ring_log_with_read_commit #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_rec_word0,
    input  wire logic [31:0] i_rec_word1,
    input  wire logic [31:0] i_rec_word2,
    input  wire logic [31:0] i_rec_word3,
    output logic             o_valid,
    output logic [31:0]      o_out_word0,
    output logic [31:0]      o_out_word1,
    output logic [31:0]      o_out_word2,
    output logic [31:0]      o_out_word3,
    output logic             o_has_record,
    output logic             o_last
);

    orl_pkg::t_dp_cmd           cmd;
    orl_pkg::t_dp_stat          stat;
    logic [orl_pkg::REC_W-1:0]  rec_in;
    logic [orl_pkg::REC_W-1:0]  rec_out;

    // word 0 in the low bits of the RAM row
    assign rec_in = {i_rec_word3, i_rec_word2, i_rec_word1, i_rec_word0};

    orl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (orl_pkg::t_op'(i_operation)),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    orl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rec        (rec_in),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_has_record (o_has_record),
        .o_last       (o_last),
        .o_rec        (rec_out)
    );

    assign o_out_word0 = rec_out[0*orl_pkg::WORD_W +: orl_pkg::WORD_W];
    assign o_out_word1 = rec_out[1*orl_pkg::WORD_W +: orl_pkg::WORD_W];
    assign o_out_word2 = rec_out[2*orl_pkg::WORD_W +: orl_pkg::WORD_W];
    assign o_out_word3 = rec_out[3*orl_pkg::WORD_W +: orl_pkg::WORD_W];

endmodule
`default_nettype wire

### hdl/orl_chk.sv
// Port-level checker for the ring log, bound to the top level.
`default_nettype none
module orl_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_operation,
    input wire logic        o_valid,
    input wire logic [31:0] o_out_word0,
    input wire logic [31:0] o_out_word1,
    input wire logic [31:0] o_out_word2,
    input wire logic [31:0] o_out_word3,
    input wire logic        o_has_record,
    input wire logic        o_last
);

    // empty marker always closes its run
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_record) |-> o_last)
        else $error("empty marker without last");

    // empty marker carries zero words
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_record) |->
            (o_out_word0 == 32'd0 && o_out_word1 == 32'd0 &&
             o_out_word2 == 32'd0 && o_out_word3 == 32'd0))
        else $error("empty marker with nonzero data");

    // only a read transaction produces results
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != orl_pkg::OP_READ) |=> !o_valid)
        else $error("result after a non-read transaction");

    // a read run streams without gaps until last
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_has_record))
        else $error("gap inside a read run");

    // no new transaction while a run is still streaming
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("not busy during a read run");

endmodule

bind overwriting_ring_log_with_read_commit orl_chk u_orl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_operation  (i_operation),
    .o_valid      (o_valid),
    .o_out_word0  (o_out_word0),
    .o_out_word1  (o_out_word1),
    .o_out_word2  (o_out_word2),
    .o_out_word3  (o_out_word3),
    .o_has_record (o_has_record),
    .o_last       (o_last)
);
`default_nettype wire

### dv/overwriting_ring_log_with_read_commit_test.sv
// Self-checking testbench for the overwriting ring log: directed, overwrite and random tests.
`default_nettype none
module overwriting_ring_log_with_read_commit_test;

    localparam int unsigned DEPTH      = 32;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    // Cycles with no accepted transaction of either kind before the run is declared hung.
    // A correct run never comes close: reads stream one record per cycle and
    // sender gaps are geometric.
    localparam int unsigned STALL_LIMIT = 2000;
    // Cycles to keep watching after the last expected record, to catch extras.
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned MAX_PRINTS  = 100;

    // One read result as the block should present it.
    typedef struct packed {
        logic [3:0][31:0] words;
        logic             has_record;
        logic             last;
    } t_ring_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [31:0] i_rec_word0;
    logic [31:0] i_rec_word1;
    logic [31:0] i_rec_word2;
    logic [31:0] i_rec_word3;
    logic        o_valid;
    logic [31:0] o_out_word0;
    logic [31:0] o_out_word1;
    logic [31:0] o_out_word2;
    logic [31:0] o_out_word3;
    logic        o_has_record;
    logic        o_last;

    overwriting_ring_log_with_read_commit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_rec_word0 (i_rec_word0),
        .i_rec_word1 (i_rec_word1),
        .i_rec_word2 (i_rec_word2),
        .i_rec_word3 (i_rec_word3),
        .o_valid     (o_valid),
        .o_out_word0 (o_out_word0),
        .o_out_word1 (o_out_word1),
        .o_out_word2 (o_out_word2),
        .o_out_word3 (o_out_word3),
        .o_has_record(o_has_record),
        .o_last      (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the ring: record words plus the three indices.
    // ------------------------------------------------------------------
    logic [3:0][31:0] shadow_ring [DEPTH];
    logic [IDX_W-1:0] shadow_wr_idx;
    logic [IDX_W-1:0] shadow_commit_idx;
    logic [IDX_W-1:0] shadow_cursor;

    // Records the block still owes us, oldest first.
    t_ring_result due_records [$];

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned send_gap_pct   = 0;   // chance per cycle that the sender holds off
    int unsigned stall_cycles   = 0;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    // Apply one accepted command to the shadow ring and queue the records it yields.
    task automatic ring_log_apply(input orl_pkg::t_op op, input logic [3:0][31:0] words);
        t_ring_result r;
        case (op)
            orl_pkg::OP_WRITE: begin
                shadow_ring[shadow_wr_idx] = words;
                shadow_wr_idx = ring_next(shadow_wr_idx);
                // Ring full: the oldest pending record is lost.
                if (shadow_wr_idx == shadow_cursor)
                    shadow_cursor = ring_next(shadow_cursor);
                if (shadow_wr_idx == shadow_commit_idx)
                    shadow_commit_idx = ring_next(shadow_commit_idx);
            end
            orl_pkg::OP_READ: begin
                if (shadow_cursor == shadow_wr_idx) begin
                    // Nothing pending: one empty marker, words zero.
                    r.words      = '0;
                    r.has_record = 1'b0;
                    r.last       = 1'b1;
                    due_records.push_back(r);
                end else begin
                    while (shadow_cursor != shadow_wr_idx) begin
                        r.words      = shadow_ring[shadow_cursor];
                        r.has_record = 1'b1;
                        shadow_cursor = ring_next(shadow_cursor);
                        r.last       = (shadow_cursor == shadow_wr_idx);
                        due_records.push_back(r);
                    end
                end
            end
            orl_pkg::OP_COMMIT: shadow_commit_idx = shadow_cursor;
            default: begin
                // Clear all: indices only, record words survive.
                shadow_wr_idx     = '0;
                shadow_commit_idx = '0;
                shadow_cursor     = '0;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker and hang watchdog. Sampled at the rising edge, so the
    // values seen are the ones the block held during the cycle just ended.
    // ------------------------------------------------------------------
    t_ring_result     exp_rec;
    logic [3:0][31:0] seen_words;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                seen_words = {o_out_word3, o_out_word2, o_out_word1, o_out_word0};
                if (due_records.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, words %h", seen_words));
                end else begin
                    exp_rec = due_records.pop_front();
                    for (int w = 0; w < 4; w++)
                        if (seen_words[w] !== exp_rec.words[w])
                            flag_mismatch($sformatf("out_word%0d got %h want %h",
                                w, seen_words[w], exp_rec.words[w]));
                    if (o_has_record !== exp_rec.has_record)
                        flag_mismatch($sformatf("has_record got %b want %b",
                            o_has_record, exp_rec.has_record));
                    if (o_last !== exp_rec.last)
                        flag_mismatch($sformatf("last got %b want %b",
                            o_last, exp_rec.last));
                end
            end
            // Watchdog: any command or result transaction counts as progress.
            if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("overwriting_ring_log_with_read_commit_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)  return '0;
        if (pick < 16) return '1;
        return $urandom;
    endfunction

    function automatic logic [3:0][31:0] rand_record();
        logic [3:0][31:0] rec;
        for (int w = 0; w < 4; w++)
            rec[w] = rand_word();
        return rec;
    endfunction

    // Send one command transaction; returns in the step where it was accepted.
    // start is only lowered when a gap is taken, so it is never dropped and
    // raised in the same step.
    task automatic send_cmd(input orl_pkg::t_op op, input logic [3:0][31:0] words);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_rec_word0 <= words[0];
        i_rec_word1 <= words[1];
        i_rec_word2 <= words[2];
        i_rec_word3 <= words[3];
        do @(posedge i_clk); while (busy !== 1'b0);
        ring_log_apply(op, words);
        items_sent++;
    endtask

    // Hold the sender off until every owed record has come out.
    // Always waits for at least the next edge, so a following send never re-raises start in this step.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (due_records.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the record words, every operation, empty reads, clear drops pending records.
    task automatic test_directed();
        send_cmd(orl_pkg::OP_READ, '0);                 // empty marker straight out of reset
        send_cmd(orl_pkg::OP_WRITE, {4{32'h0000_0000}});
        send_cmd(orl_pkg::OP_WRITE, {4{32'hFFFF_FFFF}});
        send_cmd(orl_pkg::OP_WRITE,
            {32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h8000_0001, 32'h7FFF_FFFE});
        send_cmd(orl_pkg::OP_WRITE,
            {32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE, 32'h7FFF_FFFF});
        send_cmd(orl_pkg::OP_READ, '0);                 // four records, last on the fourth
        send_cmd(orl_pkg::OP_COMMIT, '1);
        send_cmd(orl_pkg::OP_READ, '1);                 // drained: empty marker
        send_cmd(orl_pkg::OP_WRITE,
            {32'hDEAD_0001, 32'hDEAD_0002, 32'hDEAD_0003, 32'hDEAD_0004});
        send_cmd(orl_pkg::OP_CLEAR, '0);                // pending record dropped
        send_cmd(orl_pkg::OP_READ, '0);                 // empty after clear
        send_cmd(orl_pkg::OP_WRITE,
            {32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
        send_cmd(orl_pkg::OP_READ, '0);                 // single record, last set
        send_cmd(orl_pkg::OP_COMMIT, '0);
        send_cmd(orl_pkg::OP_CLEAR, '1);
    endtask

    // Overfill the ring: oldest records are overwritten and one read returns
    // a full run of DEPTH-1 records.
    task automatic test_overwrite();
        logic [3:0][31:0] rec;
        send_cmd(orl_pkg::OP_COMMIT, '0);
        for (int n = 0; n < DEPTH + 2; n++) begin
            rec = {32'hC000_0000 | n, 32'hB000_0000 | n, 32'hA000_0000 | n, ~32'(n)};
            send_cmd(orl_pkg::OP_WRITE, rec);
        end
        wait_drained();
        send_cmd(orl_pkg::OP_READ, '0);
        // Pause with the sender idle until the whole run is out.
        wait_drained();
        send_cmd(orl_pkg::OP_READ, '0);
        send_cmd(orl_pkg::OP_CLEAR, '0);
    endtask

    // Random traffic: mostly write bursts closed by a read, some noise and
    // some broken sequences.
    task automatic test_random(input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        int unsigned n_writes;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)      n_writes = $urandom_range(0, 6);
                else if (pick < 95) n_writes = $urandom_range(7, DEPTH - 1);
                else                n_writes = $urandom_range(DEPTH, DEPTH + 6);
                repeat (n_writes) send_cmd(orl_pkg::OP_WRITE, rand_record());
                send_cmd(orl_pkg::OP_READ, rand_record());
                if ($urandom_range(0, 99) < 50) send_cmd(orl_pkg::OP_COMMIT, rand_record());
                if ($urandom_range(0, 99) < 10) send_cmd(orl_pkg::OP_READ, rand_record());
                if ($urandom_range(0, 99) < 10) send_cmd(orl_pkg::OP_CLEAR, rand_record());
            end else if (pick < 90) begin
                send_cmd(orl_pkg::t_op'($urandom_range(0, 3)), rand_record());
            end else begin
                // Writes thrown away by a clear before anyone reads them.
                repeat ($urandom_range(1, 5)) send_cmd(orl_pkg::OP_WRITE, rand_record());
                send_cmd(orl_pkg::OP_CLEAR, rand_record());
                send_cmd(orl_pkg::OP_READ, rand_record());
            end
            if ($urandom_range(0, 99) < 5)
                wait_drained();
        end
    endtask

    initial begin
        shadow_wr_idx     = '0;
        shadow_commit_idx = '0;
        shadow_cursor     = '0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= orl_pkg::OP_WRITE;
        i_rec_word0 <= '0;
        i_rec_word1 <= '0;
        i_rec_word2 <= '0;
        i_rec_word3 <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 25;
        test_directed();
        test_overwrite();
        test_random(55);

        send_gap_pct = 50;
        test_random(55);

        send_gap_pct = 0;
        test_random(55);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_records.size() != 0)
            flag_mismatch($sformatf("%0d records never arrived", due_records.size()));
        if (mismatch_count == 0)
            $display("overwriting_ring_log_with_read_commit_test: PASS");
        else
            $display("overwriting_ring_log_with_read_commit_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
